/* hw/rtl/hspc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Handle shape pixel classifier package
// Register map, shape and region codes, field widths and reset values shared
// by the classifier and its port checker.
// ----------------------------------------------------------------------------
package hspc_pkg;

	localparam int COORD_BITS_DEF = 8;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	localparam int SHAPE_BITS  = 3;
	localparam int HW_BITS     = 8;
	localparam int BAND_BITS   = 4;
	localparam int SCALE_BITS  = 3;
	localparam int SCALED_BITS = SCALE_BITS + BAND_BITS;
	localparam int COLOUR_BITS = 32;
	localparam int REGION_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SHAPE_KIND     = 3'd0,
		CFG_HANDLE_WIDTH   = 3'd1,
		CFG_STROKE_WIDTH   = 3'd2,
		CFG_OUTLINE_WIDTH  = 3'd3,
		CFG_DEVICE_SCALE   = 3'd4,
		CFG_FILL_COLOUR    = 3'd5,
		CFG_STROKE_COLOUR  = 3'd6,
		CFG_OUTLINE_COLOUR = 3'd7
	} cfg_index_t;

	typedef enum logic [SHAPE_BITS-1:0] {
		SHAPE_SQUARE  = 3'd0,
		SHAPE_DIAMOND = 3'd1,
		SHAPE_CIRCLE  = 3'd2,
		SHAPE_XCROSS  = 3'd3,
		SHAPE_PLUS    = 3'd4
	} shape_t;

	typedef enum logic [REGION_BITS-1:0] {
		REGION_BG      = 2'd0,
		REGION_OUTLINE = 2'd1,
		REGION_STROKE  = 2'd2,
		REGION_FILL    = 2'd3
	} region_t;

	localparam logic [SHAPE_BITS-1:0]  SHAPE_KIND_RST     = 3'd0;
	localparam logic [HW_BITS-1:0]     HANDLE_WIDTH_RST   = 8'd13;
	localparam logic [BAND_BITS-1:0]   STROKE_WIDTH_RST   = 4'd1;
	localparam logic [BAND_BITS-1:0]   OUTLINE_WIDTH_RST  = 4'd0;
	localparam logic [SCALE_BITS-1:0]  DEVICE_SCALE_RST   = 3'd1;
	localparam logic [COLOUR_BITS-1:0] FILL_COLOUR_RST    = 32'hFFFF_FFFF;
	localparam logic [COLOUR_BITS-1:0] STROKE_COLOUR_RST  = 32'h0000_00FF;
	localparam logic [COLOUR_BITS-1:0] OUTLINE_COLOUR_RST = 32'h0000_0000;

endpackage : hspc_pkg
`default_nettype wire

/* hw/rtl/handle_shape_pixel_classifier.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: a result passes the input register, square stage, compare stage and
//   output register in that order.
// Throughput: one pixel per cycle; each stage holds only while the one after it is full.
// Reset: arst_n clears every valid bit and loads the register reset values;
//   the squared band limits have no reset and follow the registers in the next cycle.
// ----------------------------------------------------------------------------
// Handle shape pixel classifier
// Classifies one handle sprite pixel as fill, stroke, outline or background
// for the configured shape and returns the matching colour.
// ----------------------------------------------------------------------------
module handle_shape_pixel_classifier #(
	parameter int COORD_BITS = hspc_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [hspc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [hspc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [COORD_BITS-1:0]             row,
	input  logic [COORD_BITS-1:0]             col,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [hspc_pkg::COLOUR_BITS-1:0]  pixel_colour,
	output logic [hspc_pkg::REGION_BITS-1:0]  region
);
	import hspc_pkg::*;

	// signed linear quantities, magnitudes fed to squarers, squares, sums of two squares
	localparam int DW  = COORD_BITS + 6;
	localparam int MW  = COORD_BITS + 4;
	localparam int SW  = 2 * MW;
	localparam int SW1 = SW + 1;

	localparam logic signed [DW-1:0] ONE_S = DW'(1);
	localparam logic signed [DW-1:0] TWO_S = DW'(2);

	function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] a;
		a = (v < 0) ? -v : v;
		return a[MW-1:0];
	endfunction

	// 2*v^2 <= k^2
	function automatic logic le_over_root2(input logic [SW-1:0] v2, input logic [SW-1:0] k2);
		return {v2, 1'b0} <= {1'b0, k2};
	endfunction

	// v == 0, or w - v >= 0 and k^2 <= 2*(w - v)^2
	function automatic logic le_rest(input logic v_zero, input logic d_neg,
			input logic [SW-1:0] d2, input logic [SW-1:0] k2);
		return v_zero || (!d_neg && ({1'b0, k2} <= {d2, 1'b0}));
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [SHAPE_BITS-1:0]  shape_kind_q;
	logic [HW_BITS-1:0]     handle_width_q;
	logic [BAND_BITS-1:0]   stroke_width_q;
	logic [BAND_BITS-1:0]   outline_width_q;
	logic [SCALE_BITS-1:0]  device_scale_q;
	logic [COLOUR_BITS-1:0] fill_colour_q;
	logic [COLOUR_BITS-1:0] stroke_colour_q;
	logic [COLOUR_BITS-1:0] outline_colour_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_kind_q     <= SHAPE_KIND_RST;
			handle_width_q   <= HANDLE_WIDTH_RST;
			stroke_width_q   <= STROKE_WIDTH_RST;
			outline_width_q  <= OUTLINE_WIDTH_RST;
			device_scale_q   <= DEVICE_SCALE_RST;
			fill_colour_q    <= FILL_COLOUR_RST;
			stroke_colour_q  <= STROKE_COLOUR_RST;
			outline_colour_q <= OUTLINE_COLOUR_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SHAPE_KIND:     shape_kind_q     <= cfg_wdata[SHAPE_BITS-1:0];
				CFG_HANDLE_WIDTH:   handle_width_q   <= cfg_wdata[HW_BITS-1:0];
				CFG_STROKE_WIDTH:   stroke_width_q   <= cfg_wdata[BAND_BITS-1:0];
				CFG_OUTLINE_WIDTH:  outline_width_q  <= cfg_wdata[BAND_BITS-1:0];
				CFG_DEVICE_SCALE:   device_scale_q   <= cfg_wdata[SCALE_BITS-1:0];
				CFG_FILL_COLOUR:    fill_colour_q    <= cfg_wdata[COLOUR_BITS-1:0];
				CFG_STROKE_COLOUR:  stroke_colour_q  <= cfg_wdata[COLOUR_BITS-1:0];
				CFG_OUTLINE_COLOUR: outline_colour_q <= cfg_wdata[COLOUR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// width register truncated to its low COORD_BITS bits
	logic [COORD_BITS+HW_BITS-1:0] hw_ext;
	logic [COORD_BITS-1:0]         w_u;
	logic [SCALED_BITS-1:0]        so_u, ss_u;
	logic signed [DW-1:0]          w_s, so_s, ss_s;

	assign hw_ext = {{COORD_BITS{1'b0}}, handle_width_q};
	assign w_u    = hw_ext[COORD_BITS-1:0];
	assign so_u   = SCALED_BITS'(device_scale_q * outline_width_q);
	assign ss_u   = SCALED_BITS'(device_scale_q * stroke_width_q);
	assign w_s    = $signed({{(DW-COORD_BITS){1'b0}}, w_u});
	assign so_s   = $signed({{(DW-SCALED_BITS){1'b0}}, so_u});
	assign ss_s   = $signed({{(DW-SCALED_BITS){1'b0}}, ss_u});

	// Squared band limits for the circle and the cross; used two stages after
	// the input register, so registering them behind the registers is in time.
	logic signed [DW-1:0] k1_s, k2_s, f_s, s_s;
	logic [SW-1:0]        w_sq_q, f_sq_q, s_sq_q, ss_sq_q, k1_sq_q, k2_sq_q;

	assign k1_s = (so_s <<< 1) + ss_s;
	assign k2_s = (so_s <<< 2) + ss_s;
	assign f_s  = w_s - ((ss_s + so_s) <<< 1);
	assign s_s  = w_s - (so_s <<< 1);

	always_ff @(posedge clk) begin
		w_sq_q  <= mag(w_s) * mag(w_s);
		f_sq_q  <= mag(f_s) * mag(f_s);
		s_sq_q  <= mag(s_s) * mag(s_s);
		ss_sq_q <= mag(ss_s) * mag(ss_s);
		k1_sq_q <= mag(k1_s) * mag(k1_s);
		k2_sq_q <= mag(k2_s) * mag(k2_s);
	end

	// ------------------------------------------------------------------
	// Pipeline flow control
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic en_s1, en_s2, en_s3, en_out;

	assign en_out   = !out_valid_q || out_ready;
	assign en_s3    = !valid_s3 || en_out;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  valid_s1    <= in_valid;
			if (en_s2)  valid_s2    <= valid_s1;
			if (en_s3)  valid_s3    <= valid_s2;
			if (en_out) out_valid_q <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register, linear tests
	// ------------------------------------------------------------------
	logic [COORD_BITS-1:0] row_s1, col_s1;

	always_ff @(posedge clk) begin
		if (in_valid && en_s1) begin
			row_s1 <= row;
			col_s1 <= col;
		end
	end

	logic signed [DW-1:0] r_s, c_s, sos_s;
	logic                 outside;
	logic                 sq_band1, sq_band2;
	logic signed [DW-1:0] r_flip, c_flip, mr_s, mc_s, dsum_s, m_s;
	logic                 dm_fill, dm_stroke, dm_outline;
	logic signed [DW-1:0] ctr_s, ax_s, ay_s;
	logic                 pl_stroke, pl_outline;
	logic signed [DW-1:0] dr_s, dc_s, a_s, b_s, da_s, db_s;
	region_t              region_lin;

	assign r_s     = $signed({{(DW-COORD_BITS){1'b0}}, row_s1});
	assign c_s     = $signed({{(DW-COORD_BITS){1'b0}}, col_s1});
	assign sos_s   = so_s + ss_s;
	assign outside = (row_s1 >= w_u) || (col_s1 >= w_u);

	// square: distance to the nearest edge
	assign sq_band1 = (r_s < so_s) || (c_s < so_s) ||
		(w_s - r_s <= so_s) || (w_s - c_s <= so_s);
	assign sq_band2 = (r_s < sos_s) || (c_s < sos_s) ||
		(w_s - r_s <= sos_s) || (w_s - c_s <= sos_s);

	// diamond: smallest corner sum splits into row and column minima
	assign r_flip     = w_s - ONE_S - r_s;
	assign c_flip     = w_s - ONE_S - c_s;
	assign mr_s       = (r_s < r_flip) ? r_s : r_flip;
	assign mc_s       = (c_s < c_flip) ? c_s : c_flip;
	assign dsum_s     = mr_s + mc_s;
	assign m_s        = (w_s + ONE_S) >>> 1;
	assign dm_fill    = dsum_s > m_s - ONE_S + sos_s;
	assign dm_stroke  = dsum_s > m_s - ONE_S + so_s;
	assign dm_outline = dsum_s > m_s - TWO_S;

	// plus: doubled distance to the center lines
	assign ctr_s      = w_s >>> 1;
	assign ax_s       = (c_s < ctr_s) ? ((ctr_s - c_s) <<< 1) : ((c_s - ctr_s) <<< 1);
	assign ay_s       = (r_s < ctr_s) ? ((ctr_s - r_s) <<< 1) : ((r_s - ctr_s) <<< 1);
	assign pl_stroke  = ((ax_s < ss_s) || (ay_s < ss_s)) &&
		(c_s >= so_s) && (r_s >= so_s) &&
		(w_s - c_s >= so_s + ONE_S) && (w_s - r_s >= so_s + ONE_S);
	assign pl_outline = (ax_s < ss_s + (so_s <<< 1)) || (ay_s < ss_s + (so_s <<< 1));

	// circle and cross operands for the squarers
	assign dr_s = (r_s <<< 1) - w_s + ONE_S;
	assign dc_s = (c_s <<< 1) - w_s + ONE_S;
	assign a_s  = (c_s < r_s) ? (r_s - c_s) : (c_s - r_s);
	assign b_s  = (c_s + r_s < w_s) ? (w_s - c_s - r_s) : (c_s + r_s - w_s);
	assign da_s = w_s - a_s;
	assign db_s = w_s - b_s;

	always_comb begin
		region_lin = REGION_BG;
		case (shape_kind_q)
			SHAPE_SQUARE: begin
				if (sq_band1)
					region_lin = REGION_OUTLINE;
				else if (sq_band2)
					region_lin = REGION_STROKE;
				else
					region_lin = REGION_FILL;
			end
			SHAPE_DIAMOND: begin
				if (dm_fill)
					region_lin = REGION_FILL;
				else if (dm_stroke)
					region_lin = REGION_STROKE;
				else if (dm_outline)
					region_lin = REGION_OUTLINE;
				else
					region_lin = REGION_BG;
			end
			SHAPE_PLUS: begin
				if (pl_stroke)
					region_lin = REGION_STROKE;
				else if (pl_outline)
					region_lin = REGION_OUTLINE;
				else
					region_lin = REGION_BG;
			end
			default: region_lin = REGION_BG;
		endcase
		if (outside)
			region_lin = REGION_BG;
	end

	// ------------------------------------------------------------------
	// Stage 2: squares
	// ------------------------------------------------------------------
	region_t       region_lin_s2;
	logic          outside_s2, da_neg_s2, db_neg_s2, a_zero_s2, b_zero_s2;
	logic [MW-1:0] dr_mag_s2, dc_mag_s2, a_mag_s2, b_mag_s2, da_mag_s2, db_mag_s2;

	always_ff @(posedge clk) begin
		if (valid_s1 && en_s2) begin
			region_lin_s2 <= region_lin;
			outside_s2    <= outside;
			dr_mag_s2     <= mag(dr_s);
			dc_mag_s2     <= mag(dc_s);
			a_mag_s2      <= mag(a_s);
			b_mag_s2      <= mag(b_s);
			da_mag_s2     <= mag(da_s);
			db_mag_s2     <= mag(db_s);
			da_neg_s2     <= da_s < 0;
			db_neg_s2     <= db_s < 0;
			a_zero_s2     <= a_s == 0;
			b_zero_s2     <= b_s == 0;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: compares against the squared limits
	// ------------------------------------------------------------------
	region_t       region_lin_s3;
	logic          outside_s3, da_neg_s3, db_neg_s3, a_zero_s3, b_zero_s3;
	logic [SW-1:0] dr2_s3, dc2_s3, a2_s3, b2_s3, da2_s3, db2_s3;

	always_ff @(posedge clk) begin
		if (valid_s2 && en_s3) begin
			region_lin_s3 <= region_lin_s2;
			outside_s3    <= outside_s2;
			da_neg_s3     <= da_neg_s2;
			db_neg_s3     <= db_neg_s2;
			a_zero_s3     <= a_zero_s2;
			b_zero_s3     <= b_zero_s2;
			dr2_s3        <= dr_mag_s2 * dr_mag_s2;
			dc2_s3        <= dc_mag_s2 * dc_mag_s2;
			a2_s3         <= a_mag_s2 * a_mag_s2;
			b2_s3         <= b_mag_s2 * b_mag_s2;
			da2_s3        <= da_mag_s2 * da_mag_s2;
			db2_s3        <= db_mag_s2 * db_mag_s2;
		end
	end

	logic [SW1-1:0]         rad_sum;
	logic                   x_stroke, x_outline;
	region_t                region_fin;
	logic [COLOUR_BITS-1:0] colour_fin;

	assign rad_sum = {1'b0, dr2_s3} + {1'b0, dc2_s3};

	assign x_stroke =
		(le_rest(a_zero_s3, da_neg_s3, da2_s3, k2_sq_q) && le_over_root2(b2_s3, ss_sq_q)) ||
		(le_over_root2(a2_s3, ss_sq_q) && le_rest(b_zero_s3, db_neg_s3, db2_s3, k2_sq_q));
	assign x_outline =
		(le_rest(a_zero_s3, da_neg_s3, da2_s3, k1_sq_q) && le_over_root2(b2_s3, k1_sq_q)) ||
		(le_over_root2(a2_s3, k1_sq_q) && le_rest(b_zero_s3, db_neg_s3, db2_s3, k1_sq_q));

	always_comb begin
		region_fin = region_lin_s3;
		case (shape_kind_q)
			SHAPE_CIRCLE: begin
				if (rad_sum < {1'b0, f_sq_q})
					region_fin = REGION_FILL;
				else if (rad_sum < {1'b0, s_sq_q})
					region_fin = REGION_STROKE;
				else if (rad_sum < {1'b0, w_sq_q})
					region_fin = REGION_OUTLINE;
				else
					region_fin = REGION_BG;
			end
			SHAPE_XCROSS: begin
				if (x_stroke)
					region_fin = REGION_STROKE;
				else if (x_outline)
					region_fin = REGION_OUTLINE;
				else
					region_fin = REGION_BG;
			end
			default: region_fin = region_lin_s3;
		endcase
		if (outside_s3)
			region_fin = REGION_BG;
	end

	always_comb begin
		case (region_fin)
			REGION_OUTLINE: colour_fin = outline_colour_q;
			REGION_STROKE:  colour_fin = stroke_colour_q;
			REGION_FILL:    colour_fin = fill_colour_q;
			default:        colour_fin = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [COLOUR_BITS-1:0] pixel_colour_q;
	region_t                region_q;

	always_ff @(posedge clk) begin
		if (valid_s3 && en_out) begin
			pixel_colour_q <= colour_fin;
			region_q       <= region_fin;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_colour = pixel_colour_q;
	assign region       = region_q;

endmodule : handle_shape_pixel_classifier
`default_nettype wire

/* hw/rtl/hspc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Handle shape pixel classifier port checker
// Watches the classifier's handshake and result ports over time.
// ----------------------------------------------------------------------------
module hspc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [hspc_pkg::COLOUR_BITS-1:0] pixel_colour,
	input logic [hspc_pkg::REGION_BITS-1:0] region
);
	import hspc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_colour) && $stable(region))
		else $error("result changed while stalled");

	// background pixels carry no colour
	a_bg_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (region == REGION_BG) |-> pixel_colour == '0)
		else $error("background result with nonzero colour");

	// input only stalls behind a waiting result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a transfer reaches the output while out_ready stays high behind it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing after pipeline latency");

endmodule : hspc_checker

bind handle_shape_pixel_classifier hspc_checker u_hspc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.pixel_colour (pixel_colour),
	.region       (region)
);
`default_nettype wire
